@@ sv/dsc_pkg.sv @@
// Shared types, constants and calendar tables of the date/serial converter.
package dsc_pkg;

   localparam int unsigned DAY_W  = 5;
   localparam int unsigned MON_W  = 4;
   localparam int unsigned YEAR_W = 12;
   localparam int unsigned SER_W  = 17;
   localparam int unsigned WDAY_W = 3;
   localparam int unsigned K_W    = 8;   // years since 1900, 0..199
   localparam int unsigned DOY_W  = 9;   // day of year, 1..366
   localparam int unsigned PART_W = 9;   // month start + leap + day, up to 366
   localparam int unsigned LCNT_W = 6;   // leap days before the year, up to 50
   localparam int unsigned X_W    = SER_W + 2;   // 4 * (serial - 1)

   localparam logic [YEAR_W-1:0] YEAR_MIN   = 12'd1900;
   localparam logic [YEAR_W-1:0] YEAR_MAX   = 12'd2099;
   localparam logic [SER_W-1:0]  SERIAL_MAX = 17'd73050;
   localparam logic [X_W-1:0]    QUAD_DAYS  = 19'd1461;   // days in four years
   localparam logic [SER_W-1:0]  YEAR_DAYS  = 17'd365;

   // floor(2^30 / 1461); the quotient estimate is low by at most one
   localparam int unsigned       RECIP_SHIFT = 30;
   localparam int unsigned       RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_QUAD = 20'd734936;
   localparam int unsigned       PROD_W      = X_W + RECIP_W;

   typedef enum logic {
      OP_TO_SERIAL = 1'b0,
      OP_TO_DATE   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_YEAR   = 2'd1,
      ERR_SERIAL = 2'd2
   } err_type;

   // days before the first of month idx + 1 in a common year
   function automatic logic [PART_W-1:0] month_start(input logic [MON_W-1:0] idx);
      logic [PART_W-1:0] days;
      case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         4'd12:   days = 9'd365;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   typedef struct packed {
      op_type              op;
      logic [DAY_W-1:0]    day;
      logic [MON_W-1:0]    month;
      logic [YEAR_W-1:0]   year;
      logic [SER_W-1:0]    serial;
   } req_type;

   typedef struct packed {
      op_type              op;
      err_type             err;
      logic [DAY_W-1:0]    day;
      logic [MON_W-1:0]    month;
      logic [YEAR_W-1:0]   year;
      logic [SER_W-1:0]    serial;
      logic [K_W-1:0]      k;
      logic [PART_W-1:0]   part;
      logic [LCNT_W-1:0]   leap_cnt;
      logic [K_W-1:0]      quot_est;
   } dec_type;

   typedef struct packed {
      op_type              op;
      err_type             err;
      logic [DAY_W-1:0]    day;
      logic [MON_W-1:0]    month;
      logic [YEAR_W-1:0]   year;
      logic [SER_W-1:0]    serial;
      logic [K_W-1:0]      k;
   } yr_type;

   typedef struct packed {
      op_type              op;
      err_type             err;
      logic [DAY_W-1:0]    day;
      logic [MON_W-1:0]    month;
      logic [YEAR_W-1:0]   year;
      logic [SER_W-1:0]    serial;
      logic [WDAY_W-1:0]   weekday;
      logic [DOY_W-1:0]    doy;
      logic                leap;
   } doy_type;

   typedef struct packed {
      logic [SER_W-1:0]    serial;
      logic [DAY_W-1:0]    day;
      logic [MON_W-1:0]    month;
      logic [YEAR_W-1:0]   year;
      logic [WDAY_W-1:0]   weekday;
      err_type             err;
   } rsp_type;

endpackage

@@ sv/dsc_decode.sv @@
// Stage 1: range checks, month clamp, month offset, leap count and quotient estimate.
module dsc_decode import dsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  req_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output dec_type dn_data
);

   logic              vld_ff, vld_in;
   dec_type           data_ff, data_in;
   logic [YEAR_W-1:0] year_off;
   logic [K_W-1:0]    k;
   logic [K_W-1:0]    k_m1;
   logic [MON_W-1:0]  month;
   logic              leap;
   logic              year_bad;
   logic              serial_bad;
   logic [SER_W-1:0]  s_m1;
   logic [X_W-1:0]    x;
   logic [PROD_W-1:0] prod;

   always_comb begin
      year_off = up_data.year - YEAR_MIN;
      k        = year_off[K_W-1:0];
      k_m1     = k - 8'd1;
      year_bad = (up_data.year < YEAR_MIN) || (up_data.year > YEAR_MAX);
      if (up_data.month == 4'd0) begin
         month = 4'd1;
      end else if (up_data.month > 4'd12) begin
         month = 4'd12;
      end else begin
         month = up_data.month;
      end
      leap = (k[1:0] == 2'd0) && (k != 8'd0);

      serial_bad = (up_data.serial == 17'd0) || (up_data.serial > SERIAL_MAX);
      s_m1       = up_data.serial - 17'd1;
      x          = {s_m1, 2'b00};
      prod       = PROD_W'(x) * PROD_W'(RECIP_QUAD);

      data_in.op     = up_data.op;
      data_in.day    = up_data.day;
      data_in.month  = month;
      data_in.year   = up_data.year;
      data_in.serial = up_data.serial;
      data_in.k      = k;
      data_in.part   = month_start(month - 4'd1)
                     + PART_W'(leap && (month > 4'd2))
                     + PART_W'(up_data.day);
      data_in.leap_cnt = (k == 8'd0) ? 6'd0 : (k_m1[K_W-1:2] + 6'd1);
      data_in.quot_est = prod[RECIP_SHIFT+K_W-1:RECIP_SHIFT];
      if (up_data.op == OP_TO_SERIAL) begin
         data_in.err = year_bad ? ERR_YEAR : ERR_NONE;
      end else begin
         data_in.err = serial_bad ? ERR_SERIAL : ERR_NONE;
      end
   end

   assign up_ready = !vld_ff || dn_ready;
   assign vld_in   = up_ready ? up_valid : vld_ff;
   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ sv/dsc_year.sv @@
// Stage 2: serial sum for dates, corrected year quotient for serials.
module dsc_year import dsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  dec_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output yr_type  dn_data
);

   logic             vld_ff, vld_in;
   yr_type           data_ff, data_in;
   logic [SER_W-1:0] ser_sum;
   logic [SER_W-1:0] s_m1;
   logic [X_W-1:0]   x;
   logic [X_W-1:0]   rem;

   always_comb begin
      ser_sum = SER_W'(up_data.k) * YEAR_DAYS
              + SER_W'(up_data.part)
              + SER_W'(up_data.leap_cnt);

      // bump the estimate when a whole four-year span is still left over
      s_m1 = up_data.serial - 17'd1;
      x    = {s_m1, 2'b00};
      rem  = x - X_W'(up_data.quot_est) * QUAD_DAYS;

      data_in.op    = up_data.op;
      data_in.err   = up_data.err;
      data_in.day   = up_data.day;
      data_in.month = up_data.month;
      data_in.year  = up_data.year;
      if (up_data.op == OP_TO_SERIAL) begin
         data_in.serial = ser_sum;
         data_in.k      = up_data.k;
      end else begin
         data_in.serial = up_data.serial;
         data_in.k      = (rem >= QUAD_DAYS) ? (up_data.quot_est + 8'd1) : up_data.quot_est;
      end
   end

   assign up_ready = !vld_ff || dn_ready;
   assign vld_in   = up_ready ? up_valid : vld_ff;
   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ sv/dsc_doy.sv @@
// Stage 3: weekday by octal digit folding, day of year, year and gap check.
module dsc_doy import dsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  yr_type  up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output doy_type dn_data
);

   logic             vld_ff, vld_in;
   doy_type          data_ff, data_in;
   logic [SER_W:0]   wv;
   logic [5:0]       dsum;
   logic [3:0]       fold1;
   logic [3:0]       fold2;
   logic [2:0]       wrem;
   logic [X_W-1:0]   start;
   logic [SER_W-1:0] doy_full;
   logic             leap;

   always_comb begin
      // 8 = 1 mod 7, so summing octal digits keeps the residue
      wv   = (SER_W+1)'(up_data.serial) + 18'd6;
      dsum = 6'd0;
      for (int i = 0; i < 6; i++) begin
         dsum = dsum + 6'(wv[3*i +: 3]);
      end
      fold1 = 4'(dsum[5:3]) + 4'(dsum[2:0]);
      fold2 = 4'(fold1[3]) + 4'(fold1[2:0]);
      wrem  = (fold2 == 4'd7) ? 3'd0 : fold2[2:0];

      start    = (X_W'(up_data.k) * QUAD_DAYS + 19'd3) >> 2;
      doy_full = up_data.serial - start[SER_W-1:0];
      leap     = (up_data.k[1:0] == 2'd0) && (up_data.k != 8'd0);

      data_in.op      = up_data.op;
      data_in.day     = up_data.day;
      data_in.month   = up_data.month;
      data_in.serial  = up_data.serial;
      data_in.weekday = wrem + 3'd1;
      data_in.doy     = doy_full[DOY_W-1:0];
      data_in.leap    = leap;
      data_in.err     = up_data.err;
      if (up_data.op == OP_TO_SERIAL) begin
         data_in.year = up_data.year;
      end else begin
         data_in.year = YEAR_MIN + YEAR_W'(up_data.k);
         // serial 366 falls in the gap after the last day of 1900
         if ((up_data.err == ERR_NONE) && (doy_full > YEAR_DAYS + SER_W'(leap))) begin
            data_in.err = ERR_SERIAL;
         end
      end
   end

   assign up_ready = !vld_ff || dn_ready;
   assign vld_in   = up_ready ? up_valid : vld_ff;
   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ sv/dsc_month.sv @@
// Stage 4: month search over the cumulative table and final result register.
module dsc_month import dsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    up_valid,
   output logic    up_ready,
   input  doy_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output rsp_type dn_data
);

   logic              vld_ff, vld_in;
   rsp_type           data_ff, data_in;
   logic [MON_W-1:0]  past;
   logic [MON_W-1:0]  month;
   logic [PART_W-1:0] thr;
   logic [PART_W-1:0] day_full;

   always_comb begin
      // count month starts strictly below the day of year
      past = 4'd0;
      for (int i = 1; i < 12; i++) begin
         thr = month_start(MON_W'(i)) + PART_W'(up_data.leap && (i >= 2));
         if (up_data.doy > thr) begin
            past = past + 4'd1;
         end
      end
      month    = past + 4'd1;
      day_full = up_data.doy - month_start(past)
               - PART_W'(up_data.leap && (month > 4'd2));

      data_in.serial  = up_data.serial;
      data_in.year    = up_data.year;
      data_in.weekday = up_data.weekday;
      data_in.err     = up_data.err;
      if (up_data.op == OP_TO_SERIAL) begin
         data_in.day   = up_data.day;
         data_in.month = up_data.month;
      end else begin
         data_in.day   = day_full[DAY_W-1:0];
         data_in.month = month;
      end
      if (up_data.err != ERR_NONE) begin
         data_in.serial  = '0;
         data_in.day     = '0;
         data_in.month   = '0;
         data_in.year    = '0;
         data_in.weekday = '0;
      end
   end

   assign up_ready = !vld_ff || dn_ready;
   assign vld_in   = up_ready ? up_valid : vld_ff;
   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ sv/date_serial_converter.sv @@
// Top level of the calendar date / day serial converter, four-stage pipeline.
//
//   channel   direction  tdata                                   tuser
//   req_      in         day, month, year, serial (40 bits)      op
//   rsp_      out        serial, day, month, year, wday (48 b)   error code
//
// The result reaches rsp_ through four register stages; one item enters per
// cycle unless a stall on rsp_ holds the flow. The register stages are:
// decode and reciprocal multiply, year sum / quotient fix, day of year and
// weekday, month search. Reset clears only the stage valid bits. Each stage
// takes a new item when it is empty or its successor takes its own, so a
// stall on rsp_ backs up stage by stage while bubbles ahead still fill.
module date_serial_converter import dsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: day[4:0], month[8:5], year[20:9], serial[37:21], zero pad[39:38]
   input  logic [39:0] req_tdata,
   // req_tuser: op[0] (0 date to serial, 1 serial to date)
   input  logic [0:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: serial[16:0], day[21:17], month[25:22], year[37:26],
   //            weekday[40:38], zero pad[47:41]
   output logic [47:0] rsp_tdata,
   // rsp_tuser: error_code[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   req_type req;
   dec_type dec_data;
   yr_type  yr_data;
   doy_type doy_data;
   rsp_type rsp;
   logic    dec_valid, dec_ready;
   logic    yr_valid, yr_ready;
   logic    doy_valid, doy_ready;

   // unpack the input transfer
   always_comb begin
      req.op     = op_type'(req_tuser[0]);
      req.day    = req_tdata[4:0];
      req.month  = req_tdata[8:5];
      req.year   = req_tdata[20:9];
      req.serial = req_tdata[37:21];
   end

   dsc_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (req),
      .dn_valid (dec_valid),
      .dn_ready (dec_ready),
      .dn_data  (dec_data)
   );

   dsc_year u_year (
      .clock    (clock),
      .reset    (reset),
      .up_valid (dec_valid),
      .up_ready (dec_ready),
      .up_data  (dec_data),
      .dn_valid (yr_valid),
      .dn_ready (yr_ready),
      .dn_data  (yr_data)
   );

   dsc_doy u_doy (
      .clock    (clock),
      .reset    (reset),
      .up_valid (yr_valid),
      .up_ready (yr_ready),
      .up_data  (yr_data),
      .dn_valid (doy_valid),
      .dn_ready (doy_ready),
      .dn_data  (doy_data)
   );

   // last stage doubles as the output register
   dsc_month u_month (
      .clock    (clock),
      .reset    (reset),
      .up_valid (doy_valid),
      .up_ready (doy_ready),
      .up_data  (doy_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp)
   );

   // pack the result transfer
   assign rsp_tdata = {7'd0, rsp.weekday, rsp.year, rsp.month, rsp.day, rsp.serial};
   assign rsp_tuser = rsp.err;

endmodule
